FILE: rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int ElemW = 32;
  localparam int NumW = 33;
  localparam int TraceW = 34;
  localparam int ArgW = 35;
  localparam int SqrtLat = 32;
  localparam int DivLat = 35;
  localparam int Latency = 3 + SqrtLat + DivLat + 1;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_AX = 2'd1;
  localparam logic [1:0] BR_BY = 2'd2;
  localparam logic [1:0] BR_CZ = 2'd3;

  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [NumW-1:0] num_t;

endpackage

FILE: rtl/rmq_sqrt.sv
module rmq_sqrt (
  input  logic                        clk,
  input  logic [rmq_pkg::ArgW-1:0]    arg,
  output logic [31:0]                 root
);

  logic [35:0] rem_q  [0:32];
  logic [31:0] root_q [0:32];
  logic [63:0] rad_q  [0:32];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = {1'b0, arg, 28'b0};

  for (genvar k = 0; k < 32; k++) begin : g_step
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;

    assign r2    = {rem_q[k][33:0], rad_q[k][63:62]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (ge) begin
        rem_q[k+1]  <= r2 - trial;
        root_q[k+1] <= {root_q[k][30:0], 1'b1};
      end else begin
        rem_q[k+1]  <= r2;
        root_q[k+1] <= {root_q[k][30:0], 1'b0};
      end
      rad_q[k+1] <= {rad_q[k][61:0], 2'b00};
    end
  end

  assign root = root_q[32];

endmodule

FILE: rtl/rmq_div.sv
module rmq_div (
  input  logic                clk,
  input  rmq_pkg::num_t       num,
  input  logic [31:0]         divisor,
  output rmq_pkg::elem_t      quot
);

  logic [32:0] mag;
  logic        ovf_in;

  logic        neg_q [0:33];
  logic        ovf_q [0:33];
  logic [31:0] rem_q [0:33];
  logic [32:0] dbit_q [0:33];
  logic [31:0] dv_q  [0:33];
  logic [32:0] quo_q [0:33];

  assign mag    = num[32] ? 33'(-num) : 33'(num);
  assign ovf_in = {4'b0, mag} >= {divisor, 5'b0};

  always_ff @(posedge clk) begin
    neg_q[0]  <= num[32];
    ovf_q[0]  <= ovf_in;
    rem_q[0]  <= {4'b0, mag[32:5]};
    dbit_q[0] <= {mag[4:0], 28'b0};
    dv_q[0]   <= divisor;
    quo_q[0]  <= '0;
  end

  for (genvar k = 0; k < 33; k++) begin : g_step
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;

    assign r2   = {rem_q[k], dbit_q[k][32]};
    assign ge   = r2 >= {1'b0, dv_q[k]};
    assign diff = r2 - {1'b0, dv_q[k]};

    always_ff @(posedge clk) begin
      rem_q[k+1]  <= ge ? diff[31:0] : r2[31:0];
      quo_q[k+1]  <= {quo_q[k][31:0], ge};
      dbit_q[k+1] <= {dbit_q[k][31:0], 1'b0};
      dv_q[k+1]   <= dv_q[k];
      neg_q[k+1]  <= neg_q[k];
      ovf_q[k+1]  <= ovf_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_q[33]) begin
      if (ovf_q[33] || quo_q[33] > 33'h080000000) begin
        quot <= 32'sh80000000;
      end else begin
        quot <= -$signed(quo_q[33][31:0]);
      end
    end else begin
      if (ovf_q[33] || quo_q[33] > 33'h07FFFFFFF) begin
        quot <= 32'sh7FFFFFFF;
      end else begin
        quot <= $signed(quo_q[33][31:0]);
      end
    end
  end

endmodule

FILE: rtl/rotation_matrix_to_quaternion.sv
// Channel   Handshake      Payload
// request   start / busy   elem_ax .. elem_cz
// result    done           quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate
//
// One request per cycle; busy stays low, so every start is taken.
// Each result passes through the 32-stage square root and then the
// 35-stage divider lanes that follow it.
// rst clears every valid flag; requests in flight are dropped.
// done is a one-cycle strobe and results are never held back.
module rotation_matrix_to_quaternion (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rmq_pkg::elem_t      elem_ax,
  input  rmq_pkg::elem_t      elem_ay,
  input  rmq_pkg::elem_t      elem_az,
  input  rmq_pkg::elem_t      elem_bx,
  input  rmq_pkg::elem_t      elem_by,
  input  rmq_pkg::elem_t      elem_bz,
  input  rmq_pkg::elem_t      elem_cx,
  input  rmq_pkg::elem_t      elem_cy,
  input  rmq_pkg::elem_t      elem_cz,
  output logic                done,
  output rmq_pkg::elem_t      quat_w,
  output rmq_pkg::elem_t      quat_x,
  output rmq_pkg::elem_t      quat_y,
  output rmq_pkg::elem_t      quat_z,
  output logic [1:0]          branch_taken,
  output logic                degenerate
);

  localparam int SL = rmq_pkg::SqrtLat;
  localparam int DL = rmq_pkg::DivLat;

  logic v1, v2, v3;
  logic signed [33:0] tr1, tr2;
  rmq_pkg::elem_t ax1, by1, cz1;
  rmq_pkg::num_t cy_m_bz, az_m_cx, bx_m_ay, bx_p_ay, az_p_cx, cy_p_bz;
  logic [1:0] br_next, br2, br3;
  logic signed [33:0] best_next, best2;
  rmq_pkg::num_t n2 [0:5];
  rmq_pkg::num_t l3 [0:2];
  logic signed [35:0] arg_full;
  logic [rmq_pkg::ArgW-1:0] arg3;

  logic [31:0] root;
  logic        vs [0:SL-1];
  logic [1:0]  bs [0:SL-1];
  rmq_pkg::num_t ls [0:SL-1][0:2];

  logic        vd [0:DL-1];
  logic [1:0]  bd [0:DL-1];
  logic [31:0] cd [0:DL-1];
  rmq_pkg::elem_t lq [0:2];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    tr1 <= 34'(elem_ax) + 34'(elem_by) + 34'(elem_cz);
    ax1 <= elem_ax;
    by1 <= elem_by;
    cz1 <= elem_cz;
    cy_m_bz <= 33'(elem_cy) - 33'(elem_bz);
    az_m_cx <= 33'(elem_az) - 33'(elem_cx);
    bx_m_ay <= 33'(elem_bx) - 33'(elem_ay);
    bx_p_ay <= 33'(elem_bx) + 33'(elem_ay);
    az_p_cx <= 33'(elem_az) + 33'(elem_cx);
    cy_p_bz <= 33'(elem_cy) + 33'(elem_bz);
  end

  always_comb begin
    best_next = tr1;
    br_next   = rmq_pkg::BR_TRACE;
    if (34'(ax1) > best_next) begin
      best_next = 34'(ax1);
      br_next   = rmq_pkg::BR_AX;
    end
    if (34'(by1) > best_next) begin
      best_next = 34'(by1);
      br_next   = rmq_pkg::BR_BY;
    end
    if (34'(cz1) > best_next) begin
      best_next = 34'(cz1);
      br_next   = rmq_pkg::BR_CZ;
    end
  end

  always_ff @(posedge clk) begin
    br2   <= br_next;
    best2 <= best_next;
    tr2   <= tr1;
    n2[0] <= cy_m_bz;
    n2[1] <= az_m_cx;
    n2[2] <= bx_m_ay;
    n2[3] <= bx_p_ay;
    n2[4] <= az_p_cx;
    n2[5] <= cy_p_bz;
  end

  always_comb begin
    if (br2 == rmq_pkg::BR_TRACE) begin
      arg_full = 36'(tr2) + rmq_pkg::ONE_Q30;
    end else begin
      arg_full = (36'(best2) <<< 1) - 36'(tr2) + rmq_pkg::ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    arg3 <= arg_full[35] ? '0 : arg_full[34:0];
    br3  <= br2;
    case (br2)
      rmq_pkg::BR_TRACE: begin
        l3[0] <= n2[0];
        l3[1] <= n2[1];
        l3[2] <= n2[2];
      end
      rmq_pkg::BR_AX: begin
        l3[0] <= n2[0];
        l3[1] <= n2[3];
        l3[2] <= n2[4];
      end
      rmq_pkg::BR_BY: begin
        l3[0] <= n2[1];
        l3[1] <= n2[3];
        l3[2] <= n2[5];
      end
      default: begin
        l3[0] <= n2[2];
        l3[1] <= n2[4];
        l3[2] <= n2[5];
      end
    endcase
  end

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .arg  (arg3),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SL; i++) vs[i] <= 1'b0;
    end else begin
      vs[0] <= v3;
      for (int i = 1; i < SL; i++) vs[i] <= vs[i-1];
    end
  end

  always_ff @(posedge clk) begin
    bs[0] <= br3;
    for (int j = 0; j < 3; j++) ls[0][j] <= l3[j];
    for (int i = 1; i < SL; i++) begin
      bs[i] <= bs[i-1];
      for (int j = 0; j < 3; j++) ls[i][j] <= ls[i-1][j];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    rmq_div u_div (
      .clk     (clk),
      .num     (ls[SL-1][j]),
      .divisor (root),
      .quot    (lq[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) vd[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      vd[0] <= vs[SL-1];
      for (int i = 1; i < DL; i++) vd[i] <= vd[i-1];
      done <= vd[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    bd[0] <= bs[SL-1];
    cd[0] <= root;
    for (int i = 1; i < DL; i++) begin
      bd[i] <= bd[i-1];
      cd[i] <= cd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    branch_taken <= bd[DL-1];
    degenerate   <= cd[DL-1] == '0;
    if (cd[DL-1] == '0) begin
      quat_w <= '0;
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else begin
      case (bd[DL-1])
        rmq_pkg::BR_TRACE: begin
          quat_w <= $signed(cd[DL-1]);
          quat_x <= lq[0];
          quat_y <= lq[1];
          quat_z <= lq[2];
        end
        rmq_pkg::BR_AX: begin
          quat_x <= $signed(cd[DL-1]);
          quat_w <= lq[0];
          quat_y <= lq[1];
          quat_z <= lq[2];
        end
        rmq_pkg::BR_BY: begin
          quat_y <= $signed(cd[DL-1]);
          quat_w <= lq[0];
          quat_x <= lq[1];
          quat_z <= lq[2];
        end
        default: begin
          quat_z <= $signed(cd[DL-1]);
          quat_w <= lq[0];
          quat_x <= lq[1];
          quat_y <= lq[2];
        end
      endcase
    end
  end

endmodule

FILE: rtl/rmq_checker.sv
module rmq_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input rmq_pkg::elem_t      quat_w,
  input rmq_pkg::elem_t      quat_x,
  input rmq_pkg::elem_t      quat_y,
  input rmq_pkg::elem_t      quat_z,
  input logic [1:0]          branch_taken,
  input logic                degenerate
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(rmq_pkg::Latency) done)
    else $error("result missing after request");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0))
    else $error("degenerate result not zero");

  a_trace_positive: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate && branch_taken == rmq_pkg::BR_TRACE) |-> (quat_w > 0))
    else $error("scalar part not positive on trace branch");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .quat_w       (quat_w),
  .quat_x       (quat_x),
  .quat_y       (quat_y),
  .quat_z       (quat_z),
  .branch_taken (branch_taken),
  .degenerate   (degenerate)
);

FILE: sim/tb_rotation_matrix_to_quaternion.sv
module tb_rotation_matrix_to_quaternion;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic [1:0] br;
    logic deg;
  } quat_t;

  class quat_scoreboard;
    quat_t pending[$];
    int errors = 0;

    function automatic logic signed [31:0] quarter_div(longint num, longint unsigned c);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag << 28) / c;
      if (num < 0) return (q > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(q));
      return (q > 64'd2147483647) ? 32'sh7fffffff : $signed(q[31:0]);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic void note_request(rmq_pkg::elem_t m[9]);
      longint ax, ay, az, bx, by, bz, cx, cy, cz, tr, best, arg;
      longint unsigned c;
      quat_t e;
      ax = m[0]; ay = m[1]; az = m[2];
      bx = m[3]; by = m[4]; bz = m[5];
      cx = m[6]; cy = m[7]; cz = m[8];
      tr = ax + by + cz;
      best = tr;
      e = '{0, 0, 0, 0, rmq_pkg::BR_TRACE, 1'b0};
      if (ax > best) begin best = ax; e.br = rmq_pkg::BR_AX; end
      if (by > best) begin best = by; e.br = rmq_pkg::BR_BY; end
      if (cz > best) begin best = cz; e.br = rmq_pkg::BR_CZ; end
      arg = (e.br == rmq_pkg::BR_TRACE) ? tr + 64'sd1073741824
                                        : 2 * best - tr + 64'sd1073741824;
      if (arg < 0) arg = 0;
      c = int_sqrt(longint'(arg) << 28);
      if (c == 0) e.deg = 1'b1;
      else case (e.br)
        rmq_pkg::BR_TRACE: begin
          e.w = 32'(c); e.x = quarter_div(cy - bz, c);
          e.y = quarter_div(az - cx, c); e.z = quarter_div(bx - ay, c);
        end
        rmq_pkg::BR_AX: begin
          e.x = 32'(c); e.w = quarter_div(cy - bz, c);
          e.y = quarter_div(bx + ay, c); e.z = quarter_div(az + cx, c);
        end
        rmq_pkg::BR_BY: begin
          e.y = 32'(c); e.w = quarter_div(az - cx, c);
          e.x = quarter_div(bx + ay, c); e.z = quarter_div(cy + bz, c);
        end
        default: begin
          e.z = 32'(c); e.w = quarter_div(bx - ay, c);
          e.x = quarter_div(az + cx, c); e.y = quarter_div(cy + bz, c);
        end
      endcase
      pending.push_back(e);
    endfunction

    function automatic void check_result(quat_t a);
      quat_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result w=%h", $time, a.w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.w !== e.w) begin $display("%0t w exp %h got %h", $time, e.w, a.w); errors++; end
      if (a.x !== e.x) begin $display("%0t x exp %h got %h", $time, e.x, a.x); errors++; end
      if (a.y !== e.y) begin $display("%0t y exp %h got %h", $time, e.y, a.y); errors++; end
      if (a.z !== e.z) begin $display("%0t z exp %h got %h", $time, e.z, a.z); errors++; end
      if (a.br !== e.br) begin
        $display("%0t branch exp %0d got %0d", $time, e.br, a.br); errors++;
      end
      if (a.deg !== e.deg) begin
        $display("%0t degenerate exp %0d got %0d", $time, e.deg, a.deg); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy, done, degenerate;
  rmq_pkg::elem_t elem[9];
  rmq_pkg::elem_t quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_taken;
  quat_scoreboard sb = new();
  int idle_pct = 7;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .elem_ax(elem[0]), .elem_ay(elem[1]), .elem_az(elem[2]),
    .elem_bx(elem[3]), .elem_by(elem[4]), .elem_bz(elem[5]),
    .elem_cx(elem[6]), .elem_cy(elem[7]), .elem_cz(elem[8]),
    .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .branch_taken(branch_taken), .degenerate(degenerate)
  );

  initial for (int i = 0; i < 9; i++) elem[i] = '0;

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(elem);
    if (!rst && done) sb.check_result('{quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate});
  end

  task automatic send_request(rmq_pkg::elem_t m[9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    for (int i = 0; i < 9; i++) elem[i] <= m[i];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic rmq_pkg::elem_t rand_elem();
    case ($urandom_range(5))
      0: return rmq_pkg::elem_t'($urandom);
      1: return rmq_pkg::elem_t'($urandom_range(2)) * 32'sh40000000 - 32'sh40000000;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      3: return rmq_pkg::elem_t'($urandom_range(4)) - 2;
      default: return rmq_pkg::elem_t'(int'($urandom_range(32'h7fffffff)) >>>
                                       $urandom_range(1)) - 32'sh20000000;
    endcase
  endfunction

  task automatic send_rotation();
    real qa, qb, qc, qd, n, s;
    rmq_pkg::elem_t m[9];
    real r[9];
    qa = $urandom_range(2000) - 1000.0; qb = $urandom_range(2000) - 1000.0;
    qc = $urandom_range(2000) - 1000.0; qd = $urandom_range(2000) - 1000.0;
    n = qa*qa + qb*qb + qc*qc + qd*qd + 1.0;
    s = 2.0 / n;
    r[0] = 1 - s*(qc*qc + qd*qd); r[1] = s*(qb*qc - qd*qa); r[2] = s*(qb*qd + qc*qa);
    r[3] = s*(qb*qc + qd*qa); r[4] = 1 - s*(qb*qb + qd*qd); r[5] = s*(qc*qd - qb*qa);
    r[6] = s*(qb*qd - qc*qa); r[7] = s*(qc*qd + qb*qa); r[8] = 1 - s*(qb*qb + qc*qc);
    for (int i = 0; i < 9; i++) m[i] = rmq_pkg::elem_t'($rtoi(r[i] * 1073741824.0));
    send_request(m);
  endtask

  initial begin
    rmq_pkg::elem_t m[9];
    int guard;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    m = '{32'sh40000000, 0, 0, 0, 32'sh40000000, 0, 0, 0, 32'sh40000000};
    send_request(m);
    m = '{32'sh40000000, 0, 0, 0, 32'shc0000000, 0, 0, 0, 32'shc0000000};
    send_request(m);
    m = '{32'shc0000000, 0, 0, 0, 32'sh40000000, 0, 0, 0, 32'shc0000000};
    send_request(m);
    m = '{32'shc0000000, 0, 0, 0, 32'shc0000000, 0, 0, 0, 32'sh40000000};
    send_request(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_request(m);
    m = '{32'shc0000000, 0, 0, 0, 32'shc0000000, 0, 0, 0, 32'shc0000000};
    send_request(m);
    for (int i = 0; i < 9; i++) m[i] = 32'sh80000000;
    send_request(m);
    for (int i = 0; i < 9; i++) m[i] = 32'sh7fffffff;
    send_request(m);
    m = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_request(m);
    m = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000};
    send_request(m);
    m = '{1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff,
          32'sh7fffffff, 32'sh80000000, 0};
    send_request(m);
    m = '{32'shc0000001, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'shc0000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'shffffffff};
    send_request(m);
    m = '{5, 3, 0, 0, 5, 0, 0, 0, 5};
    send_request(m);
    for (int k = 0; k < 1800; k++) begin
      idle_pct = (k >= 600 && k < 900) ? 0 : 7;
      if ($urandom_range(99) < 70) send_rotation();
      else begin
        for (int i = 0; i < 9; i++) m[i] = rand_elem();
        send_request(m);
      end
    end
    start <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (rmq_pkg::Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("[rotation_matrix_to_quaternion] OK");
    else $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end
endmodule
